### hw/rtl/frt_pkg.sv
// Shared types and constants for the fragment reassembly tracker.
// Used by frt_front, frt_back and the top level; depends on nothing.
package frt_pkg;

  // Receive buffer size and per-packet payload limit in bytes.
  localparam logic [16:0] BufferBytes = 17'd65536;
  localparam logic [10:0] MaxPayload  = 11'd1024;

  // Reset value of the capacity register.
  localparam logic [16:0] CapReset = 17'd65536;

  // Saturation value of the loss counter.
  localparam logic [31:0] LossMax = 32'hFFFF_FFFF;

  // Depth of the two small queues (command queue and result queue).
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [1:0] {
    VerdictAccepted = 2'd0,
    VerdictStale    = 2'd1,
    VerdictOrder    = 2'd2,
    VerdictReset    = 2'd3
  } verdict_e;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic        is_reset;
    logic [63:0] seq_id;
    logic [63:0] seq_id_m1;
    logic [14:0] frag_index;
    logic        final_flag;
    logic [10:0] payload_len;
  } cmd_t;

  // One result item.
  typedef struct packed {
    verdict_e    verdict;
    logic [16:0] write_offset;
    logic [10:0] bytes_taken;
    logic        message_done;
    logic [16:0] message_length;
    logic [31:0] loss_total;
  } res_t;

endpackage

### hw/rtl/frt_front.sv
// Front end: accepts header requests, classifies them and queues them.
// Depends on frt_pkg for the command type and queue constants.
module frt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                kind_i,
  input  logic [63:0]         seq_id_i,
  input  logic [14:0]         frag_index_i,
  input  logic                final_flag_i,
  input  logic [10:0]         payload_length_i,
  output frt_pkg::cmd_t       cmd_o,
  input  logic                cmd_ready_i,
  output logic                cmd_valid_o
);
  import frt_pkg::*;

  cmd_t             cmd_in;
  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             wr_en;
  logic             rd_en;

  // Classify the incoming header: clip the payload, precompute id minus one.
  always_comb begin
    cmd_in.is_reset    = kind_i;
    cmd_in.seq_id      = seq_id_i;
    cmd_in.seq_id_m1   = seq_id_i - 64'd1;
    cmd_in.frag_index  = frag_index_i;
    cmd_in.final_flag  = final_flag_i;
    cmd_in.payload_len = (payload_length_i > MaxPayload) ? MaxPayload : payload_length_i;
  end

  assign full        = (cnt_q == QCntW'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign wr_en       = push && !full;
  assign rd_en       = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  // Queue pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage holds the classified commands; it has no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### hw/rtl/frt_back.sv
// Back end: holds the connection state, executes queued requests and
// queues their results. Depends on frt_pkg for the command and result types.
module frt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [16:0]         cfg_wdata_i,
  input  frt_pkg::cmd_t       cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  output frt_pkg::res_t       res_o,
  output logic                empty,
  input  logic                pop
);
  import frt_pkg::*;

  // Configuration and connection state.
  logic [16:0] cap_cfg_q;
  logic [63:0] last_id_q, last_id_d;
  logic [31:0] lost_q, lost_d;
  logic [16:0] bytes_q, bytes_d;
  logic [14:0] expect_q, expect_d;
  logic [63:0] asm_id_q, asm_id_d;
  logic        active_q, active_d;

  // Result queue.
  res_t             rmem_q [QDepth];
  logic [QPtrW-1:0] rwr_ptr_q, rrd_ptr_q;
  logic [QCntW-1:0] rcnt_q, rcnt_d;
  logic             res_full;
  logic             do_cmd;
  logic             do_pop;

  // Datapath intermediates.
  res_t        res_new;
  logic        restart;
  logic [63:0] gap;
  logic [32:0] loss_sum;
  logic [31:0] lost_restart;
  logic [16:0] eff_bytes;
  logic [14:0] eff_expect;
  logic [16:0] cap;
  logic [16:0] room;
  logic [10:0] take;
  logic [16:0] bytes_after;

  assign res_full    = (rcnt_q == QCntW'(QDepth));
  assign cmd_ready_o = !res_full;
  assign do_cmd      = cmd_valid_i && !res_full;
  assign empty       = (rcnt_q == '0);
  assign do_pop      = pop && !empty;
  assign res_o       = rmem_q[rrd_ptr_q];

  // Loss for a new id: ids skipped since the last completed message, saturating.
  always_comb begin
    gap          = cmd_i.seq_id_m1 - last_id_q;
    loss_sum     = {1'b0, lost_q} + {1'b0, gap[31:0]};
    lost_restart = ((|gap[63:32]) || loss_sum[32]) ? LossMax : loss_sum[31:0];
  end

  // Effective capacity and the clipped byte count of this fragment.
  always_comb begin
    restart     = !active_q || (cmd_i.seq_id != asm_id_q);
    eff_bytes   = restart ? '0 : bytes_q;
    eff_expect  = restart ? '0 : expect_q;
    cap         = (cap_cfg_q > BufferBytes) ? BufferBytes : cap_cfg_q;
    room        = (eff_bytes < cap) ? cap - eff_bytes : '0;
    take        = ({6'd0, cmd_i.payload_len} < room) ? cmd_i.payload_len : room[10:0];
    bytes_after = eff_bytes + {6'd0, take};
  end

  // Request execution: next state and result.
  always_comb begin
    last_id_d = last_id_q;
    lost_d    = lost_q;
    bytes_d   = bytes_q;
    expect_d  = expect_q;
    asm_id_d  = asm_id_q;
    active_d  = active_q;
    res_new   = '0;
    if (cmd_i.is_reset) begin
      last_id_d       = '0;
      lost_d          = '0;
      bytes_d         = '0;
      expect_d        = '0;
      asm_id_d        = '0;
      active_d        = 1'b0;
      res_new.verdict = VerdictReset;
    end else if (cmd_i.seq_id <= last_id_q) begin
      res_new.verdict    = VerdictStale;
      res_new.loss_total = lost_q;
    end else begin
      if (restart) begin
        lost_d   = lost_restart;
        asm_id_d = cmd_i.seq_id;
        active_d = 1'b1;
      end
      bytes_d            = eff_bytes;
      expect_d           = eff_expect;
      res_new.loss_total = lost_d;
      if (cmd_i.frag_index != eff_expect) begin
        res_new.verdict = VerdictOrder;
      end else begin
        res_new.verdict      = VerdictAccepted;
        res_new.write_offset = eff_bytes;
        res_new.bytes_taken  = take;
        bytes_d              = bytes_after;
        expect_d             = eff_expect + 15'd1;
        if (cmd_i.final_flag) begin
          res_new.message_done   = 1'b1;
          res_new.message_length = bytes_after;
          last_id_d              = cmd_i.seq_id;
          bytes_d                = '0;
          expect_d               = '0;
          active_d               = 1'b0;
        end
      end
    end
  end

  // Result queue fill count.
  always_comb begin
    rcnt_d = rcnt_q;
    if (do_cmd && !do_pop) begin
      rcnt_d = rcnt_q + 1'b1;
    end else if (do_pop && !do_cmd) begin
      rcnt_d = rcnt_q - 1'b1;
    end
  end

  // Control state, configuration and connection state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= CapReset;
      last_id_q <= '0;
      lost_q    <= '0;
      bytes_q   <= '0;
      expect_q  <= '0;
      asm_id_q  <= '0;
      active_q  <= 1'b0;
      rwr_ptr_q <= '0;
      rrd_ptr_q <= '0;
      rcnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_cfg_q <= cfg_wdata_i;
      end
      if (do_cmd) begin
        last_id_q <= last_id_d;
        lost_q    <= lost_d;
        bytes_q   <= bytes_d;
        expect_q  <= expect_d;
        asm_id_q  <= asm_id_d;
        active_q  <= active_d;
        rwr_ptr_q <= rwr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rrd_ptr_q <= rrd_ptr_q + 1'b1;
      end
      rcnt_q <= rcnt_d;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (do_cmd) begin
      rmem_q[rwr_ptr_q] <= res_new;
    end
  end

endmodule

### hw/rtl/fragment_reassembly_tracker.sv
// Top level of the fragment reassembly tracker: front end, command queue
// and back end. Depends on frt_pkg, frt_front and frt_back.
//
//   Channel   Handshake              Data
//   ------    ---------------------  ---------------------------------------------
//   input     push / full            kind, seq_id, frag_index, final_flag, length
//   result    empty / pop            verdict, offset, taken, done, length, loss
//   config    cfg_we_i               cfg_wdata_i (receive capacity)
//
// One request per cycle is sustained while full stays low; the back end executes a
// request in the cycle it leaves the two-entry command queue, and its result is
// registered in the result queue before it reaches the ports. Reset clears both
// queues and all connection state and sets the capacity to 65536. A stalled result
// side fills the result queue, then the command queue, and only then raises full.
module fragment_reassembly_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [63:0] seq_id_i,
  input  logic [14:0] frag_index_i,
  input  logic        final_flag_i,
  input  logic [10:0] payload_length_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  verdict_o,
  output logic [16:0] write_offset_o,
  output logic [10:0] bytes_taken_o,
  output logic        message_done_o,
  output logic [16:0] message_length_o,
  output logic [31:0] loss_total_o
);
  import frt_pkg::*;

  cmd_t  cmd;
  logic  cmd_valid;
  logic  cmd_ready;
  res_t  res;

  // Front end with the command queue.
  frt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .kind_i          (kind_i),
    .seq_id_i        (seq_id_i),
    .frag_index_i    (frag_index_i),
    .final_flag_i    (final_flag_i),
    .payload_length_i(payload_length_i),
    .cmd_o           (cmd),
    .cmd_ready_i     (cmd_ready),
    .cmd_valid_o     (cmd_valid)
  );

  // Back end with the connection state and result queue.
  frt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .res_o       (res),
    .empty       (empty),
    .pop         (pop)
  );

  assign verdict_o        = res.verdict;
  assign write_offset_o   = res.write_offset;
  assign bytes_taken_o    = res.bytes_taken;
  assign message_done_o   = res.message_done;
  assign message_length_o = res.message_length;
  assign loss_total_o     = res.loss_total;

endmodule

### tb/fragment_reassembly_tracker_tb.sv
// Self-checking testbench for fragment_reassembly_tracker: directed headers,
// then random message traffic in several capacity settings.
// Depends on frt_pkg and the RTL of the tracker only.
module fragment_reassembly_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frt_pkg::*;

  localparam int StallLimit = 1000;
  localparam int HoldCycles = 80;

  // One packet header as it enters the block.
  typedef struct packed {
    logic        kind;
    logic [63:0] seq_id;
    logic [14:0] frag_index;
    logic        final_flag;
    logic [10:0] payload_length;
  } hdr_t;

  typedef enum logic {StepHeader, StepCapacity} step_e;

  // One row of the directed table: a header or a capacity write.
  typedef struct {
    step_e       op;
    hdr_t        hdr;
    logic [16:0] cap;
    bit          typed;
    res_t        want;
  } plan_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic        kind_i = 1'b0;
  logic [63:0] seq_id_i = '0;
  logic [14:0] frag_index_i = '0;
  logic        final_flag_i = 1'b0;
  logic [10:0] payload_length_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  verdict_o;
  logic [16:0] write_offset_o;
  logic [10:0] bytes_taken_o;
  logic        message_done_o;
  logic [16:0] message_length_o;
  logic [31:0] loss_total_o;

  // Expected result that travels with a directed request, if it has one.
  bit   row_typed = 1'b0;
  res_t row_want = '0;

  // Shadow of the connection state and the capacity register.
  logic [16:0] cap_shadow = CapReset;
  logic [63:0] done_id = '0;
  logic [31:0] loss_cnt = '0;
  logic [16:0] fill = '0;
  logic [14:0] next_frag = '0;
  logic [63:0] cur_id = '0;
  logic        in_msg = 1'b0;

  res_t        outstanding[$];
  plan_t       plan_q[$];
  int          bad_fields = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          send_run = 0;
  int          quiet_cycles = 0;
  int          hold_asks = 0;
  bit          quiet_tail = 1'b0;
  logic [63:0] next_id = 64'd1;

  fragment_reassembly_tracker DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .seq_id_i         (seq_id_i),
    .frag_index_i     (frag_index_i),
    .final_flag_i     (final_flag_i),
    .payload_length_i (payload_length_i),
    .empty            (empty),
    .pop              (pop),
    .verdict_o        (verdict_o),
    .write_offset_o   (write_offset_o),
    .bytes_taken_o    (bytes_taken_o),
    .message_done_o   (message_done_o),
    .message_length_o (message_length_o),
    .loss_total_o     (loss_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the result of one header and advances the shadow state.
  function automatic res_t reassemble(hdr_t h);
    res_t        r;
    logic [63:0] gap;
    logic [10:0] len;
    logic [16:0] cap, room, take;
    r = '0;
    if (h.kind) begin
      done_id = '0;
      loss_cnt = '0;
      fill = '0;
      next_frag = '0;
      cur_id = '0;
      in_msg = 1'b0;
      r.verdict = VerdictReset;
    end else if (h.seq_id <= done_id) begin
      r.verdict = VerdictStale;
    end else begin
      // A new id restarts assembly and charges the skipped ids as lost.
      if (!in_msg || h.seq_id != cur_id) begin
        gap = h.seq_id - 64'd1 - done_id;
        if (gap >= 64'(LossMax - loss_cnt)) loss_cnt = LossMax;
        else loss_cnt = loss_cnt + gap[31:0];
        fill = '0;
        next_frag = '0;
        cur_id = h.seq_id;
        in_msg = 1'b1;
      end
      if (h.frag_index != next_frag) begin
        r.verdict = VerdictOrder;
      end else begin
        len = (h.payload_length > MaxPayload) ? MaxPayload : h.payload_length;
        cap = (cap_shadow > BufferBytes) ? BufferBytes : cap_shadow;
        room = (fill < cap) ? cap - fill : '0;
        take = (17'(len) < room) ? 17'(len) : room;
        r.verdict = VerdictAccepted;
        r.write_offset = fill;
        r.bytes_taken = take[10:0];
        fill = fill + take;
        next_frag = next_frag + 15'd1;
        if (h.final_flag) begin
          r.message_done = 1'b1;
          r.message_length = fill;
          done_id = h.seq_id;
          fill = '0;
          next_frag = '0;
          in_msg = 1'b0;
        end
      end
    end
    r.loss_total = loss_cnt;
    return r;
  endfunction

  function automatic hdr_t hdr(logic k, logic [63:0] s, logic [14:0] f, logic fin,
                               logic [10:0] l);
    hdr_t h;
    h = {k, s, f, fin, l};
    return h;
  endfunction

  function automatic res_t res(verdict_e v, logic [16:0] off, logic [10:0] tk, logic dn,
                               logic [16:0] ml, logic [31:0] ls);
    res_t r;
    r.verdict = v;
    r.write_offset = off;
    r.bytes_taken = tk;
    r.message_done = dn;
    r.message_length = ml;
    r.loss_total = ls;
    return r;
  endfunction

  function automatic void plan(hdr_t h, bit typed = 1'b0, res_t want = '0);
    plan_t p;
    p.op = StepHeader;
    p.hdr = h;
    p.cap = '0;
    p.typed = typed;
    p.want = want;
    plan_q = {plan_q, p};
  endfunction

  function automatic void plan_cap(logic [16:0] v);
    plan_t p;
    p.op = StepCapacity;
    p.hdr = '0;
    p.cap = v;
    p.typed = 1'b0;
    p.want = '0;
    plan_q = {plan_q, p};
  endfunction

  // Payloads are mostly legal, now and then oversized.
  function automatic logic [10:0] pick_length();
    if ($urandom_range(0, 9) == 0) return 11'($urandom_range(1025, 2047));
    return 11'($urandom_range(0, 1024));
  endfunction

  // A stray header mixed into a message.
  function automatic hdr_t noise(logic [63:0] id);
    case ($urandom_range(0, 4))
      0: return hdr(1'b0, id, 15'($urandom), 1'($urandom), pick_length());
      1: return hdr(1'b0, 64'($urandom_range(0, 3)), 15'($urandom_range(0, 3)), 1'($urandom),
                    pick_length());
      2: return hdr(1'b0, {$urandom, $urandom}, 15'($urandom), 1'($urandom), 11'($urandom));
      3: return hdr(1'b1, {$urandom, $urandom}, 15'($urandom), 1'($urandom), 11'($urandom));
      default: return hdr(1'b0, id, 15'($urandom_range(0, 2)), 1'b0, pick_length());
    endcase
  endfunction

  task automatic report(string msg);
    $display("result %0d: %s", results_seen, msg);
    bad_fields++;
  endtask

  task automatic flag_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s is %0h, predicted %0h", field, got, want));
  endtask

  // Offers one request, at times with a random gap first, and returns once it is taken.
  task automatic offer(hdr_t h, bit typed = 1'b0, res_t want = '0);
    if (!quiet_tail && send_run == 0 && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      send_run = $urandom_range(0, 30);
    end else if (send_run != 0) begin
      send_run--;
    end
    push <= 1'b1;
    kind_i <= h.kind;
    seq_id_i <= h.seq_id;
    frag_index_i <= h.frag_index;
    final_flag_i <= h.final_flag;
    payload_length_i <= h.payload_length;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // Stops sending until every outstanding result has been popped.
  task automatic settle();
    push <= 1'b0;
    do @(negedge clk_i); while (outstanding.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [16:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One message of in-order fragments with some noise; a few are abandoned.
  task automatic send_message();
    int          n;
    logic [63:0] id;
    bit          abandon;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
    case ($urandom_range(0, 19))
      0:       id = {$urandom, $urandom};
      1, 2:    id = next_id + 64'($urandom_range(1, 4));
      default: id = next_id;
    endcase
    next_id = id + 64'd1;
    abandon = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) offer(noise(id));
      offer(hdr(1'b0, id, 15'(i), !abandon && i == n - 1, pick_length()));
    end
    // After a far jump the connection is cleared half the time to keep ids fresh.
    if (id[63:40] != '0 && $urandom_range(0, 1) == 0) begin
      offer(hdr(1'b1, {$urandom, $urandom}, 15'($urandom), 1'($urandom), 11'($urandom)));
      next_id = 64'd1;
    end
  endtask

  // Predict each accepted request and check each popped result.
  always @(posedge clk_i) begin
    res_t pred;
    res_t want;
    if (rst_ni) begin
      if (cfg_we_i) cap_shadow = cfg_wdata_i;
      if (push && !full) begin
        pred = reassemble(hdr(kind_i, seq_id_i, frag_index_i, final_flag_i,
                              payload_length_i));
        outstanding.insert(outstanding.size(), row_typed ? row_want : pred);
      end
      if (pop && !empty) begin
        if (outstanding.size() == 0) begin
          report("result popped with nothing outstanding");
        end else begin
          want = outstanding.pop_front();
          flag_field("verdict", verdict_o, want.verdict);
          flag_field("write_offset", write_offset_o, want.write_offset);
          flag_field("bytes_taken", bytes_taken_o, want.bytes_taken);
          flag_field("message_done", message_done_o, want.message_done);
          flag_field("message_length", message_length_o, want.message_length);
          flag_field("loss_total", loss_total_o, want.loss_total);
        end
        results_seen++;
      end
    end
  end

  // Result side: random pop bursts, one long hold on request, steady at the end.
  initial begin
    int idle_left;
    int run_left;
    int hold_left;
    int holds_seen;
    idle_left = 0;
    run_left = 0;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (quiet_tail) begin
        pop <= 1'b1;
      end else if (idle_left != 0) begin
        idle_left--;
        pop <= 1'b0;
      end else if (run_left == 0 && $urandom_range(0, 3) == 0) begin
        idle_left = $urandom_range(1, 10) - 1;
        run_left = $urandom_range(0, 30);
        pop <= 1'b0;
      end else begin
        if (run_left != 0) run_left--;
        pop <= 1'b1;
      end
    end
  end

  // Ends the run when no request moves on either side for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("fragment_reassembly_tracker regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          mark;
    bit          held;
    logic [16:0] caps [4];
    held = 1'b0;

    // Directed table: stale, reset, clipping, order, loss and capacity cases.
    plan(hdr(1'b0, 64'd0, 15'd0, 1'b0, 11'd0), 1,
         res(VerdictStale, 17'd0, 11'd0, 1'b0, 17'd0, 32'd0));
    plan(hdr(1'b1, '1, 15'h7FFF, 1'b1, 11'h7FF), 1,
         res(VerdictReset, 17'd0, 11'd0, 1'b0, 17'd0, 32'd0));
    plan(hdr(1'b0, 64'd1, 15'd0, 1'b0, 11'd1024), 1,
         res(VerdictAccepted, 17'd0, 11'd1024, 1'b0, 17'd0, 32'd0));
    plan(hdr(1'b0, 64'd1, 15'd1, 1'b0, 11'd2047), 1,
         res(VerdictAccepted, 17'd1024, 11'd1024, 1'b0, 17'd0, 32'd0));
    plan(hdr(1'b0, 64'd1, 15'd5, 1'b0, 11'd3), 1,
         res(VerdictOrder, 17'd0, 11'd0, 1'b0, 17'd0, 32'd0));
    plan(hdr(1'b0, 64'd1, 15'd2, 1'b1, 11'd100), 1,
         res(VerdictAccepted, 17'd2048, 11'd100, 1'b1, 17'd2148, 32'd0));
    plan(hdr(1'b0, 64'd1, 15'd0, 1'b1, 11'd5), 1,
         res(VerdictStale, 17'd0, 11'd0, 1'b0, 17'd0, 32'd0));
    plan(hdr(1'b0, 64'd5, 15'd1, 1'b0, 11'd9), 1,
         res(VerdictOrder, 17'd0, 11'd0, 1'b0, 17'd0, 32'd3));
    plan(hdr(1'b0, 64'd5, 15'd0, 1'b1, 11'd0), 1,
         res(VerdictAccepted, 17'd0, 11'd0, 1'b1, 17'd0, 32'd3));
    plan(hdr(1'b0, '1, 15'd0, 1'b0, 11'd10), 1,
         res(VerdictAccepted, 17'd0, 11'd10, 1'b0, 17'd0, LossMax));
    plan(hdr(1'b0, '1, 15'd1, 1'b1, 11'd0), 1,
         res(VerdictAccepted, 17'd10, 11'd0, 1'b1, 17'd10, LossMax));
    plan(hdr(1'b0, '1, 15'd0, 1'b0, 11'd0), 1,
         res(VerdictStale, 17'd0, 11'd0, 1'b0, 17'd0, LossMax));
    plan(hdr(1'b1, 64'd0, 15'd0, 1'b0, 11'd0), 1,
         res(VerdictReset, 17'd0, 11'd0, 1'b0, 17'd0, 32'd0));
    plan_cap(17'd0);
    plan(hdr(1'b0, 64'd3, 15'd0, 1'b0, 11'd500), 1,
         res(VerdictAccepted, 17'd0, 11'd0, 1'b0, 17'd0, 32'd2));
    plan(hdr(1'b0, 64'd3, 15'd1, 1'b1, 11'd1024), 1,
         res(VerdictAccepted, 17'd0, 11'd0, 1'b1, 17'd0, 32'd2));
    plan_cap(17'd1500);
    plan(hdr(1'b0, 64'd4, 15'd0, 1'b0, 11'd1024), 1,
         res(VerdictAccepted, 17'd0, 11'd1024, 1'b0, 17'd0, 32'd2));
    plan(hdr(1'b0, 64'd4, 15'd1, 1'b0, 11'd1024), 1,
         res(VerdictAccepted, 17'd1024, 11'd476, 1'b0, 17'd0, 32'd2));
    plan(hdr(1'b0, 64'd4, 15'd2, 1'b1, 11'd7), 1,
         res(VerdictAccepted, 17'd1500, 11'd0, 1'b1, 17'd1500, 32'd2));
    plan_cap(17'h1FFFF);
    plan(hdr(1'b0, 64'd6, 15'd0, 1'b0, 11'd1025), 1,
         res(VerdictAccepted, 17'd0, 11'd1024, 1'b0, 17'd0, 32'd3));
    plan(hdr(1'b0, 64'd8, 15'd0, 1'b0, 11'd3), 1,
         res(VerdictAccepted, 17'd0, 11'd3, 1'b0, 17'd0, 32'd6));
    plan(hdr(1'b0, 64'd8, 15'd1, 1'b0, 11'd1536));
    // Lowering the capacity below what is already stored leaves no room.
    plan_cap(17'd512);
    plan(hdr(1'b0, 64'd8, 15'd2, 1'b1, 11'd1024), 1,
         res(VerdictAccepted, 17'd1027, 11'd0, 1'b1, 17'd1027, 32'd6));
    plan(hdr(1'b1, 64'h5555_5555_5555_5555, 15'h2AAA, 1'b1, 11'h555), 1,
         res(VerdictReset, 17'd0, 11'd0, 1'b0, 17'd0, 32'd0));
    plan_cap(CapReset);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].op == StepCapacity) set_capacity(plan_q[i].cap);
      else offer(plan_q[i].hdr, plan_q[i].typed, plan_q[i].want);
    end

    // Random traffic in four capacity settings; the last part runs without gaps.
    caps = '{17'($urandom_range(0, 131071)), 17'd2048, 17'd700, CapReset};
    for (int p = 0; p < 4; p++) begin
      set_capacity(caps[p]);
      mark = items_sent;
      while (items_sent - mark < 200) begin
        if (p == 0 && !held && items_sent - mark > 60) begin
          hold_asks <= hold_asks + 1;
          held = 1'b1;
        end
        if (p == 3 && items_sent - mark > 50) quiet_tail <= 1'b1;
        send_message();
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (bad_fields == 0 && outstanding.size() == 0) begin
      $display("fragment_reassembly_tracker regression: pass");
    end else begin
      $display("fragment_reassembly_tracker regression: fail");
    end
    $finish;
  end

endmodule
